[rtl/pasa_pkg.sv]
// Shared types and constants for the accelerometer pair sample assembler.
package pasa_pkg;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SECOND_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT     = 2'd2;

  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned COUNT_W = 32;

  // Operation codes of an input item
  localparam logic OP_MSG  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register reset values
  localparam logic [TYPE_W-1:0]  FIRST_CODE_RST  = 8'd1;
  localparam logic [TYPE_W-1:0]  SECOND_CODE_RST = 8'd2;
  localparam logic [COUNT_W-1:0] TIMEOUT_RST     = 32'd1000000;

  // Configuration as seen by the step logic
  typedef struct packed {
    logic [TYPE_W-1:0]  first_code;
    logic [TYPE_W-1:0]  second_code;
    logic [COUNT_W-1:0] timeout;
  } cfg_t;

  // Status flags of one result item
  typedef struct packed {
    logic handled;
    logic disconnect_seen;
    logic sample_ready;
  } flags_t;

endpackage

[rtl/pasa_cfg.sv]
// Configuration registers of the pair sample assembler.
module pasa_cfg import pasa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COUNT_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_FIRST_CODE:  cfg_d.first_code  = cfg_data_i[TYPE_W-1:0];
        CFG_IDX_SECOND_CODE: cfg_d.second_code = cfg_data_i[TYPE_W-1:0];
        CFG_IDX_TIMEOUT:     cfg_d.timeout     = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_code  <= FIRST_CODE_RST;
      cfg_q.second_code <= SECOND_CODE_RST;
      cfg_q.timeout     <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pasa_step.sv]
// Pairing state and the per-item step logic that updates it.
module pasa_step import pasa_pkg::*; #(
  parameter int unsigned ID_WIDTH   = 8,
  parameter int unsigned AXIS_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       step_en_i,
  input  logic                       op_i,
  input  logic [TYPE_W-1:0]          type_i,
  input  logic [ID_WIDTH-1:0]        id_i,
  input  logic [2:0][AXIS_WIDTH-1:0] axes_i,
  output flags_t                     flags_o,
  output logic [ID_WIDTH-1:0]        sample_id_o,
  output logic [2:0][AXIS_WIDTH-1:0] first_axes_o,
  output logic [2:0][AXIS_WIDTH-1:0] second_axes_o,
  output logic [COUNT_W-1:0]         disc_total_o,
  output logic [COUNT_W-1:0]         drop_total_o
);

  logic                       waiting_q, waiting_d;
  logic [ID_WIDTH-1:0]        held_id_q, held_id_d;
  logic [2:0][AXIS_WIDTH-1:0] held_axes_q, held_axes_d;
  logic                       no_packet_q, no_packet_d;
  logic                       no_sample_q, no_sample_d;
  logic [ID_WIDTH-1:0]        prev_id_q, prev_id_d;
  logic [COUNT_W-1:0]         silence_q, silence_d;
  logic                       disc_flag_q, disc_flag_d;
  logic [COUNT_W-1:0]         disc_cnt_q, disc_cnt_d;
  logic [COUNT_W-1:0]         drop_cnt_q, drop_cnt_d;

  logic                is_first, is_second, handled;
  logic                timeout_hit, wait_a, nosample_a, completes;
  logic [ID_WIDTH-1:0] gap;
  logic [COUNT_W:0]    drop_sum;

  // Message classification and timeout test
  assign is_first    = (type_i == cfg_i.first_code);
  assign is_second   = (type_i == cfg_i.second_code);
  assign handled     = (op_i == OP_MSG) && (is_first || is_second);
  assign timeout_hit = !no_packet_q && (silence_q >= cfg_i.timeout);
  assign wait_a      = waiting_q && !timeout_hit;
  assign nosample_a  = no_sample_q || timeout_hit;
  assign completes   = handled && wait_a && is_second && (id_i == held_id_q);

  // Skipped ids since the last sample, modulo the id range
  assign gap      = held_id_q - prev_id_q - ID_WIDTH'(1);
  assign drop_sum = {1'b0, drop_cnt_q} + (COUNT_W + 1)'(gap);

  // Next state
  always_comb begin
    waiting_d   = waiting_q;
    held_id_d   = held_id_q;
    held_axes_d = held_axes_q;
    no_packet_d = no_packet_q;
    no_sample_d = no_sample_q;
    prev_id_d   = prev_id_q;
    silence_d   = silence_q;
    disc_flag_d = disc_flag_q;
    disc_cnt_d  = disc_cnt_q;
    drop_cnt_d  = drop_cnt_q;
    if (op_i == OP_TICK) begin
      if (silence_q != '1) silence_d = silence_q + COUNT_W'(1);
    end else if (handled) begin
      disc_flag_d = timeout_hit;
      if (timeout_hit && (disc_cnt_q != '1)) disc_cnt_d = disc_cnt_q + COUNT_W'(1);
      silence_d   = '0;
      no_packet_d = 1'b0;
      no_sample_d = nosample_a;
      if (completes) begin
        waiting_d   = 1'b0;
        no_sample_d = 1'b0;
        prev_id_d   = held_id_q;
        if (!nosample_a) drop_cnt_d = drop_sum[COUNT_W] ? '1 : drop_sum[COUNT_W-1:0];
      end else if (is_first) begin
        waiting_d   = 1'b1;
        held_id_d   = id_i;
        held_axes_d = axes_i;
      end else begin
        waiting_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      held_id_q   <= '0;
      held_axes_q <= '0;
      no_packet_q <= 1'b1;
      no_sample_q <= 1'b1;
      prev_id_q   <= '0;
      silence_q   <= '0;
      disc_flag_q <= 1'b0;
      disc_cnt_q  <= '0;
      drop_cnt_q  <= '0;
    end else if (step_en_i) begin
      waiting_q   <= waiting_d;
      held_id_q   <= held_id_d;
      held_axes_q <= held_axes_d;
      no_packet_q <= no_packet_d;
      no_sample_q <= no_sample_d;
      prev_id_q   <= prev_id_d;
      silence_q   <= silence_d;
      disc_flag_q <= disc_flag_d;
      disc_cnt_q  <= disc_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
    end
  end

  // Result of this item; sample fields read zero unless a pair completes
  assign flags_o.handled         = handled;
  assign flags_o.disconnect_seen = disc_flag_d;
  assign flags_o.sample_ready    = completes;
  assign sample_id_o   = completes ? held_id_q : '0;
  assign first_axes_o  = completes ? held_axes_q : '0;
  assign second_axes_o = completes ? axes_i : '0;
  assign disc_total_o  = disc_cnt_d;
  assign drop_total_o  = drop_cnt_d;

endmodule

[rtl/accel_pair_sample_assembler_core.sv]
// Items pass the input register, then the result register. Throughput: one item per
// cycle unless back pressure stalls; input register, step logic and result register
// form a two-stage pipeline and the pairing state updates as an item leaves stage one.
// Reset (rst_ni low, asynchronous): pipeline empty, pairing state and counters
// cleared, type codes 1 and 2, timeout 1000000 ticks.
module accel_pair_sample_assembler_core import pasa_pkg::*; #(
  parameter int unsigned ID_WIDTH   = 8,
  parameter int unsigned AXIS_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [COUNT_W-1:0]           cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [TYPE_W-1:0]            msg_type_i,
  input  logic [ID_WIDTH-1:0]          msg_id_i,
  input  logic signed [AXIS_WIDTH-1:0] acc_x_i,
  input  logic signed [AXIS_WIDTH-1:0] acc_y_i,
  input  logic signed [AXIS_WIDTH-1:0] acc_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         handled_o,
  output logic                         disconnect_seen_o,
  output logic                         sample_ready_o,
  output logic [ID_WIDTH-1:0]          sample_id_o,
  output logic signed [AXIS_WIDTH-1:0] first_x_o,
  output logic signed [AXIS_WIDTH-1:0] first_y_o,
  output logic signed [AXIS_WIDTH-1:0] first_z_o,
  output logic signed [AXIS_WIDTH-1:0] second_x_o,
  output logic signed [AXIS_WIDTH-1:0] second_y_o,
  output logic signed [AXIS_WIDTH-1:0] second_z_o,
  output logic [COUNT_W-1:0]           disconnect_total_o,
  output logic [COUNT_W-1:0]           dropped_total_o
);

  cfg_t cfg;

  logic                       in_valid_q;
  logic                       op_q;
  logic [TYPE_W-1:0]          type_q;
  logic [ID_WIDTH-1:0]        id_q;
  logic [2:0][AXIS_WIDTH-1:0] axes_q;

  logic                       advance, step_en;
  flags_t                     flags;
  logic [ID_WIDTH-1:0]        sample_id;
  logic [2:0][AXIS_WIDTH-1:0] first_axes, second_axes;
  logic [COUNT_W-1:0]         disc_total, drop_total;

  logic                       out_valid_q;
  flags_t                     flags_q;
  logic [ID_WIDTH-1:0]        sample_id_q;
  logic [2:0][AXIS_WIDTH-1:0] first_axes_q, second_axes_q;
  logic [COUNT_W-1:0]         disc_total_q, drop_total_q;

  pasa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage one advances whenever the result register is free or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q      <= operation_i;
      type_q    <= msg_type_i;
      id_q      <= msg_id_i;
      axes_q[0] <= acc_x_i;
      axes_q[1] <= acc_y_i;
      axes_q[2] <= acc_z_i;
    end
  end

  pasa_step #(
    .ID_WIDTH   (ID_WIDTH),
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_en_i     (step_en),
    .op_i          (op_q),
    .type_i        (type_q),
    .id_i          (id_q),
    .axes_i        (axes_q),
    .flags_o       (flags),
    .sample_id_o   (sample_id),
    .first_axes_o  (first_axes),
    .second_axes_o (second_axes),
    .disc_total_o  (disc_total),
    .drop_total_o  (drop_total)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      flags_q       <= flags;
      sample_id_q   <= sample_id;
      first_axes_q  <= first_axes;
      second_axes_q <= second_axes;
      disc_total_q  <= disc_total;
      drop_total_q  <= drop_total;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign handled_o          = flags_q.handled;
  assign disconnect_seen_o  = flags_q.disconnect_seen;
  assign sample_ready_o     = flags_q.sample_ready;
  assign sample_id_o        = sample_id_q;
  assign first_x_o          = first_axes_q[0];
  assign first_y_o          = first_axes_q[1];
  assign first_z_o          = first_axes_q[2];
  assign second_x_o         = second_axes_q[0];
  assign second_y_o         = second_axes_q[1];
  assign second_z_o         = second_axes_q[2];
  assign disconnect_total_o = disc_total_q;
  assign dropped_total_o    = drop_total_q;

  // A completed pair is always a handled sample message
  a_ready_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && flags_q.sample_ready |-> flags_q.handled)
    else $error("sample_ready without handled");

  // Input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without back pressure");

  // Counters never go down from one result item to the next
  a_counts_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && out_valid_q |-> disc_total >= disc_total_q && drop_total >= drop_total_q)
    else $error("saturating counter decreased");

endmodule
